// ----- rtl/mos_pkg.sv -----
// Package for the median-of-two-sorted-lists block: sizes, command and
// status codes, shared types. No dependencies.
`default_nettype none

package mos_pkg;

  localparam int unsigned LIST_DEPTH = 1024;
  localparam int unsigned ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int unsigned IDX_W      = CNT_W + 1;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned RES_W      = DATA_W + 1;

  localparam logic [1:0] CMD_LOAD_ONE = 2'd0;
  localparam logic [1:0] CMD_LOAD_TWO = 2'd1;
  localparam logic [1:0] CMD_COMPUTE  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_NO_PART  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic signed [IDX_W-1:0]  idx_t;
  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [RES_W-1:0]  res_t;

  // which of the edge elements la, ra, lb and rb around a partition exist
  typedef struct packed {
    logic la_ok;
    logic ra_ok;
    logic lb_ok;
    logic rb_ok;
  } edge_ok_t;

  typedef struct packed {
    logic hit;
    logic a_fits;
    res_t twice;
  } probe_res_t;

endpackage

`default_nettype wire

// ----- rtl/mos_in_if.sv -----
// Input channel: command and value with valid/ready.
// Depends on mos_pkg.
`default_nettype none

interface mos_in_if;
  logic                valid;
  logic                ready;
  logic [1:0]          cmd;
  mos_pkg::data_t      value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

`default_nettype wire

// ----- rtl/mos_out_if.sv -----
// Result channel: doubled median and status with valid/ready.
// Depends on mos_pkg.
`default_nettype none

interface mos_out_if;
  logic                valid;
  logic                ready;
  mos_pkg::res_t       median_doubled;
  logic [1:0]          status;

  modport source (output valid, output median_doubled, output status, input ready);
  modport sink   (input valid, input median_doubled, input status, output ready);
endinterface

`default_nettype wire

// ----- rtl/mos_probe.sv -----
// Evaluates one partition probe: checks both cross conditions and forms
// twice the median from the edge elements. Depends on mos_pkg.
`default_nettype none

module mos_probe (
  input  mos_pkg::data_t     la_i,
  input  mos_pkg::data_t     ra_i,
  input  mos_pkg::data_t     lb_i,
  input  mos_pkg::data_t     rb_i,
  input  mos_pkg::edge_ok_t  ok_i,
  input  logic               odd_i,
  output mos_pkg::probe_res_t res_o
);

  logic           a_fits;
  logic           b_fits;
  mos_pkg::data_t left;
  mos_pkg::data_t right;

  always_comb begin
    a_fits = !(ok_i.la_ok && ok_i.rb_ok) || (la_i <= rb_i);
    b_fits = !(ok_i.lb_ok && ok_i.ra_ok) || (lb_i <= ra_i);

    if (ok_i.la_ok && ok_i.lb_ok) begin
      left = (la_i > lb_i) ? la_i : lb_i;
    end else begin
      left = ok_i.la_ok ? la_i : lb_i;
    end

    if (ok_i.ra_ok && ok_i.rb_ok) begin
      right = (ra_i < rb_i) ? ra_i : rb_i;
    end else begin
      right = ok_i.ra_ok ? ra_i : rb_i;
    end

    res_o.hit    = a_fits && b_fits;
    res_o.a_fits = a_fits;
    if (odd_i) begin
      res_o.twice = {left, 1'b0};
    end else begin
      res_o.twice = {left[mos_pkg::DATA_W-1], left} + {right[mos_pkg::DATA_W-1], right};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/median_of_two_sorted_arrays.sv -----
// A load yields no result; loads are taken back to back.
// Compute: binary partition search over the shorter list, each probe a memory read
// (S_PROBE) then an evaluate (S_EVAL), at most CNT_W (11) probes. A hit goes to S_DONE;
// a failed search spends one more window check in S_PROBE first; overflow or empty answers
// go straight to S_DONE, which loads the output register once it is empty or being read.
// The next item is taken once the result sits in the output register.
// Reset clears counts, overflow flag, control and output valid; list stores are not cleared.
`default_nettype none

module median_of_two_sorted_arrays (
  input  logic         clk_i,
  input  logic         rst_ni,
  mos_in_if.sink       in_i,
  mos_out_if.source    out_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PROBE = 2'd1;
  localparam logic [1:0] S_EVAL  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  mos_pkg::data_t mem_one [mos_pkg::LIST_DEPTH];
  mos_pkg::data_t mem_two [mos_pkg::LIST_DEPTH];

  logic [1:0]        state_q, state_d;
  mos_pkg::cnt_t     cnt_one_q, cnt_one_d;
  mos_pkg::cnt_t     cnt_two_q, cnt_two_d;
  logic              ovf_q, ovf_d;
  logic              swap_q, swap_d;
  mos_pkg::cnt_t     na_q, na_d;
  mos_pkg::cnt_t     nb_q, nb_d;
  mos_pkg::cnt_t     half_q, half_d;
  logic              odd_q, odd_d;
  mos_pkg::idx_t     lo_q, lo_d;
  mos_pkg::idx_t     hi_q, hi_d;
  mos_pkg::idx_t     pa_q, pa_d;
  mos_pkg::edge_ok_t ok_q, ok_d;
  logic [1:0]        res_status_q, res_status_d;
  mos_pkg::res_t     res_twice_q, res_twice_d;
  logic              out_valid_q;
  logic [1:0]        out_status_q;
  mos_pkg::res_t     out_twice_q;

  logic              in_xfer;
  logic              wr_one;
  logic              wr_two;
  logic              out_load;
  logic [mos_pkg::IDX_W:0] lohi_sum;
  mos_pkg::idx_t     pa;
  mos_pkg::idx_t     pb;
  mos_pkg::idx_t     pa_m1;
  mos_pkg::idx_t     pb_m1;
  mos_pkg::idx_t     na_s;
  mos_pkg::idx_t     nb_s;
  mos_pkg::addr_t    addr_one0, addr_one1, addr_two0, addr_two1;
  mos_pkg::data_t    rd_one0_q, rd_one1_q, rd_two0_q, rd_two1_q;
  mos_pkg::data_t    la, ra, lb, rb;
  mos_pkg::probe_res_t probe_res;
  logic [mos_pkg::CNT_W:0] n_sum;

  assign in_xfer  = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);

  // probe point for the current search window
  assign lohi_sum = {lo_q[mos_pkg::IDX_W-1], lo_q} + {hi_q[mos_pkg::IDX_W-1], hi_q};
  assign pa       = mos_pkg::idx_t'(lohi_sum[mos_pkg::IDX_W:1]);
  assign pb       = $signed({1'b0, half_q}) - pa;
  assign pa_m1    = pa - mos_pkg::idx_t'(1);
  assign pb_m1    = pb - mos_pkg::idx_t'(1);
  assign na_s     = $signed({1'b0, na_q});
  assign nb_s     = $signed({1'b0, nb_q});

  // side a is the shorter list; swap means list two plays that role
  assign addr_one0 = swap_q ? pb_m1[mos_pkg::ADDR_W-1:0] : pa_m1[mos_pkg::ADDR_W-1:0];
  assign addr_one1 = swap_q ? pb[mos_pkg::ADDR_W-1:0]    : pa[mos_pkg::ADDR_W-1:0];
  assign addr_two0 = swap_q ? pa_m1[mos_pkg::ADDR_W-1:0] : pb_m1[mos_pkg::ADDR_W-1:0];
  assign addr_two1 = swap_q ? pa[mos_pkg::ADDR_W-1:0]    : pb[mos_pkg::ADDR_W-1:0];

  assign la = swap_q ? rd_two0_q : rd_one0_q;
  assign ra = swap_q ? rd_two1_q : rd_one1_q;
  assign lb = swap_q ? rd_one0_q : rd_two0_q;
  assign rb = swap_q ? rd_one1_q : rd_two1_q;

  assign n_sum = {1'b0, cnt_one_q} + {1'b0, cnt_two_q} + (mos_pkg::CNT_W+1)'(1);

  mos_probe u_probe (
    .la_i  (la),
    .ra_i  (ra),
    .lb_i  (lb),
    .rb_i  (rb),
    .ok_i  (ok_q),
    .odd_i (odd_q),
    .res_o (probe_res)
  );

  always_comb begin
    state_d      = state_q;
    cnt_one_d    = cnt_one_q;
    cnt_two_d    = cnt_two_q;
    ovf_d        = ovf_q;
    swap_d       = swap_q;
    na_d         = na_q;
    nb_d         = nb_q;
    half_d       = half_q;
    odd_d        = odd_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    pa_d         = pa_q;
    ok_d         = ok_q;
    res_status_d = res_status_q;
    res_twice_d  = res_twice_q;
    wr_one       = 1'b0;
    wr_two       = 1'b0;
    out_load     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_i.cmd)
            mos_pkg::CMD_LOAD_ONE: begin
              if (cnt_one_q < mos_pkg::CNT_W'(mos_pkg::LIST_DEPTH)) begin
                wr_one    = 1'b1;
                cnt_one_d = cnt_one_q + mos_pkg::CNT_W'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            mos_pkg::CMD_LOAD_TWO: begin
              if (cnt_two_q < mos_pkg::CNT_W'(mos_pkg::LIST_DEPTH)) begin
                wr_two    = 1'b1;
                cnt_two_d = cnt_two_q + mos_pkg::CNT_W'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            mos_pkg::CMD_COMPUTE: begin
              swap_d    = cnt_one_q > cnt_two_q;
              na_d      = (cnt_one_q > cnt_two_q) ? cnt_two_q : cnt_one_q;
              nb_d      = (cnt_one_q > cnt_two_q) ? cnt_one_q : cnt_two_q;
              half_d    = n_sum[mos_pkg::CNT_W:1];
              odd_d     = cnt_one_q[0] ^ cnt_two_q[0];
              lo_d      = '0;
              hi_d      = (cnt_one_q > cnt_two_q) ? $signed({1'b0, cnt_two_q})
                                                  : $signed({1'b0, cnt_one_q});
              cnt_one_d = '0;
              cnt_two_d = '0;
              ovf_d     = 1'b0;
              res_twice_d = '0;
              if (ovf_q) begin
                res_status_d = mos_pkg::ST_OVERFLOW;
                state_d      = S_DONE;
              end else if (cnt_one_q == '0 && cnt_two_q == '0) begin
                res_status_d = mos_pkg::ST_EMPTY;
                state_d      = S_DONE;
              end else begin
                state_d = S_PROBE;
              end
            end
            default: ;
          endcase
        end
      end
      S_PROBE: begin
        if (lo_q > hi_q || pb < $signed(mos_pkg::IDX_W'(0)) || pb > nb_s) begin
          res_status_d = mos_pkg::ST_NO_PART;
          res_twice_d  = '0;
          state_d      = S_DONE;
        end else begin
          pa_d       = pa;
          ok_d.la_ok = pa > $signed(mos_pkg::IDX_W'(0));
          ok_d.ra_ok = pa < na_s;
          ok_d.lb_ok = pb > $signed(mos_pkg::IDX_W'(0));
          ok_d.rb_ok = pb < nb_s;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        if (probe_res.hit) begin
          res_status_d = mos_pkg::ST_OK;
          res_twice_d  = probe_res.twice;
          state_d      = S_DONE;
        end else begin
          if (!probe_res.a_fits) begin
            hi_d = pa_q - mos_pkg::idx_t'(1);
          end else begin
            lo_d = pa_q + mos_pkg::idx_t'(1);
          end
          state_d = S_PROBE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_one_q    <= '0;
      cnt_two_q    <= '0;
      ovf_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_one_q    <= cnt_one_d;
      cnt_two_q    <= cnt_two_d;
      ovf_q        <= ovf_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // search and result payload
  always_ff @(posedge clk_i) begin
    swap_q       <= swap_d;
    na_q         <= na_d;
    nb_q         <= nb_d;
    half_q       <= half_d;
    odd_q        <= odd_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    pa_q         <= pa_d;
    ok_q         <= ok_d;
    res_status_q <= res_status_d;
    res_twice_q  <= res_twice_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_twice_q  <= (res_status_q == mos_pkg::ST_OK) ? res_twice_q : '0;
    end
  end

  // list stores: one write port, two registered read ports each
  always_ff @(posedge clk_i) begin
    if (wr_one) begin
      mem_one[cnt_one_q[mos_pkg::ADDR_W-1:0]] <= in_i.value;
    end
    rd_one0_q <= mem_one[addr_one0];
    rd_one1_q <= mem_one[addr_one1];
  end

  always_ff @(posedge clk_i) begin
    if (wr_two) begin
      mem_two[cnt_two_q[mos_pkg::ADDR_W-1:0]] <= in_i.value;
    end
    rd_two0_q <= mem_two[addr_two0];
    rd_two1_q <= mem_two[addr_two1];
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = out_status_q;
  assign out_o.median_doubled = out_twice_q;

  a_zero_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status != mos_pkg::ST_OK) |-> (out_o.median_doubled == '0))
    else $error("nonzero median with error status");

  a_clear_on_compute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_i.cmd == mos_pkg::CMD_COMPUTE) |=>
      (cnt_one_q == '0 && cnt_two_q == '0 && !ovf_q))
    else $error("counts not cleared after compute");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_one_q <= mos_pkg::CNT_W'(mos_pkg::LIST_DEPTH)) &&
    (cnt_two_q <= mos_pkg::CNT_W'(mos_pkg::LIST_DEPTH)))
    else $error("list count beyond depth");

  a_lo_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE) |-> (lo_q >= $signed(mos_pkg::IDX_W'(0))))
    else $error("search lower bound negative");

endmodule

`default_nettype wire
